// ===== hdl/scis_pkg.sv =====
// Shared constants, codes and types of the simple CPU instruction step block.
// No dependencies; imported by the top level and the port checker.
`default_nettype none

package scis_pkg;

  localparam int INSTR_ADDR_BITS = 12;
  localparam int DATA_ADDR_BITS  = 12;
  localparam int CLR_BITS   = (INSTR_ADDR_BITS > DATA_ADDR_BITS) ? INSTR_ADDR_BITS
                                                                 : DATA_ADDR_BITS;
  localparam int IMEM_DEPTH = 1 << INSTR_ADDR_BITS;
  localparam int DMEM_DEPTH = 1 << DATA_ADDR_BITS;
  localparam int WORD_W     = 16;
  localparam int REG_IDX_W  = 3;
  localparam int REG_NUM    = 1 << REG_IDX_W;
  localparam int OP_W       = 7;
  localparam int OFF_W      = 2 * REG_IDX_W;

  typedef enum logic [2:0] {
    REQ_STEP     = 3'd0,
    REQ_WR_INSTR = 3'd1,
    REQ_WR_DATA  = 3'd2,
    REQ_RD_DATA  = 3'd3,
    REQ_WR_REG   = 3'd4,
    REQ_SET_PC   = 3'd5,
    REQ_RD_REG   = 3'd6,
    REQ_NONE     = 3'd7
  } req_t;

  localparam logic [OP_W-1:0] OP_MOVA = 7'h00;
  localparam logic [OP_W-1:0] OP_INC  = 7'h01;
  localparam logic [OP_W-1:0] OP_ADD  = 7'h02;
  localparam logic [OP_W-1:0] OP_SUB  = 7'h05;
  localparam logic [OP_W-1:0] OP_DEC  = 7'h06;
  localparam logic [OP_W-1:0] OP_AND  = 7'h08;
  localparam logic [OP_W-1:0] OP_OR   = 7'h09;
  localparam logic [OP_W-1:0] OP_XOR  = 7'h0A;
  localparam logic [OP_W-1:0] OP_NOT  = 7'h0B;
  localparam logic [OP_W-1:0] OP_MOVB = 7'h0C;
  localparam logic [OP_W-1:0] OP_SHR  = 7'h0D;
  localparam logic [OP_W-1:0] OP_SHL  = 7'h0E;
  localparam logic [OP_W-1:0] OP_LDI  = 7'h4C;
  localparam logic [OP_W-1:0] OP_ADI  = 7'h42;
  localparam logic [OP_W-1:0] OP_LD   = 7'h10;
  localparam logic [OP_W-1:0] OP_ST   = 7'h20;
  localparam logic [OP_W-1:0] OP_BRZ  = 7'h60;
  localparam logic [OP_W-1:0] OP_BRN  = 7'h61;
  localparam logic [OP_W-1:0] OP_JMP  = 7'h70;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_FETCH = 7'b0000100,
    ST_RDOUT = 7'b0001000,
    ST_REGRD = 7'b0010000,
    ST_EXEC  = 7'b0100000,
    ST_MEMRD = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0]    pc_after;
    logic [WORD_W-1:0]    fetched_word;
    logic                 invalid_opcode;
    logic                 branch_taken;
    logic                 reg_write_en;
    logic [REG_IDX_W-1:0] reg_index;
    logic [WORD_W-1:0]    reg_value;
    logic                 mem_write_en;
    logic [WORD_W-1:0]    mem_address;
    logic [WORD_W-1:0]    mem_value;
    logic [WORD_W-1:0]    read_data;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/simple_cpu_instruction_step.sv =====
// Top level: 16-bit textbook CPU core stepped one instruction per request, with debug access.
// Depends on scis_pkg; instruction, data and register stores are local synchronous memories.
`default_nettype none

// One request is in flight at a time; the result sits in an output register, so the next
// request is taken in the cycle its predecessor's result is registered. A step runs the fetch,
// register read and execute states (and a data store read state for a load), following the
// chain of synchronous reads; debug writes and set pc end in fetch, debug reads in readout.
// After reset a clearing pass zeroes addresses 0 to 2**max(INSTR_ADDR_BITS, DATA_ADDR_BITS)-1
// = 4095 of both stores, during which req_stall is high.
module simple_cpu_instruction_step
  import scis_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [2:0]           req_type,
  input  logic [WORD_W-1:0]    target_address,
  input  logic [WORD_W-1:0]    write_value,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [WORD_W-1:0]    pc_after,
  output logic [WORD_W-1:0]    fetched_word,
  output logic                 invalid_opcode,
  output logic                 branch_taken,
  output logic                 reg_write_en,
  output logic [REG_IDX_W-1:0] reg_index,
  output logic [WORD_W-1:0]    reg_value,
  output logic                 mem_write_en,
  output logic [WORD_W-1:0]    mem_address,
  output logic [WORD_W-1:0]    mem_value,
  output logic [WORD_W-1:0]    read_data
);

  logic [WORD_W-1:0] imem [IMEM_DEPTH];
  logic [WORD_W-1:0] dmem [DMEM_DEPTH];
  logic [WORD_W-1:0] rf   [REG_NUM];

  state_t               state, state_next;
  logic [CLR_BITS-1:0]  clr_cnt;
  req_t                 req_q;
  logic [WORD_W-1:0]    addr_q, wval_q;
  logic [WORD_W-1:0]    pc, pc_next;
  logic [WORD_W-1:0]    ir_q, dmem_q, ra_q, rb_q;
  logic                 ra_vld_q, rb_vld_q;
  logic [REG_NUM-1:0]   rf_vld;
  logic                 out_free, fin, accept;
  result_t              res, res_q;

  logic                       imem_we, imem_re;
  logic [INSTR_ADDR_BITS-1:0] imem_wa;
  logic [WORD_W-1:0]          imem_wd;
  logic                       dmem_we, dmem_re;
  logic [DATA_ADDR_BITS-1:0]  dmem_wa, dmem_ra;
  logic [WORD_W-1:0]          dmem_wd;
  logic                       rf_we, rf_re;
  logic [REG_IDX_W-1:0]       rf_wa, rf_ra_a, rf_ra_b;
  logic [WORD_W-1:0]          rf_wd;

  logic [OP_W-1:0]            op;
  logic [REG_IDX_W-1:0]       fd, fa, fb;
  logic [WORD_W-1:0]          ra, rb, off, pc_inc;
  logic [DATA_ADDR_BITS-1:0]  daddr;
  logic [WORD_W-1:0]          ex_v, ex_next;
  logic                       ex_wr, ex_valid, ex_taken, ex_ld, ex_st;

  assign op     = ir_q[WORD_W-1 -: OP_W];
  assign fd     = ir_q[3*REG_IDX_W-1 -: REG_IDX_W];
  assign fa     = ir_q[2*REG_IDX_W-1 -: REG_IDX_W];
  assign fb     = ir_q[REG_IDX_W-1:0];
  assign ra     = ra_vld_q ? ra_q : '0;
  assign rb     = rb_vld_q ? rb_q : '0;
  assign off    = {{(WORD_W-OFF_W){fd[REG_IDX_W-1]}}, fd, fb};
  assign pc_inc = pc + WORD_W'(1);
  assign daddr  = ra[DATA_ADDR_BITS-1:0];

  assign out_free  = !res_valid || !res_stall;
  assign req_stall = !((state == ST_IDLE) || fin);
  assign accept    = req_valid && !req_stall;

  always_comb begin
    ex_v     = '0;
    ex_wr    = 1'b1;
    ex_valid = 1'b1;
    ex_next  = pc_inc;
    ex_taken = 1'b0;
    ex_ld    = 1'b0;
    ex_st    = 1'b0;
    unique case (op)
      OP_MOVA: ex_v = ra;
      OP_INC:  ex_v = ra + WORD_W'(1);
      OP_ADD:  ex_v = ra + rb;
      OP_SUB:  ex_v = ra - rb;
      OP_DEC:  ex_v = ra - WORD_W'(1);
      OP_AND:  ex_v = ra & rb;
      OP_OR:   ex_v = ra | rb;
      OP_XOR:  ex_v = ra ^ rb;
      OP_NOT:  ex_v = ~ra;
      OP_MOVB: ex_v = rb;
      OP_SHR:  ex_v = {1'b0, rb[WORD_W-1:1]};
      OP_SHL:  ex_v = {rb[WORD_W-2:0], 1'b0};
      OP_LDI:  ex_v = WORD_W'(fb);
      OP_ADI:  ex_v = ra + WORD_W'(fb);
      OP_LD:   ex_ld = 1'b1;
      OP_ST: begin
        ex_wr = 1'b0;
        ex_st = 1'b1;
      end
      OP_BRZ: begin
        ex_wr = 1'b0;
        if (ra == '0) begin
          ex_next  = pc + off;
          ex_taken = 1'b1;
        end
      end
      OP_BRN: begin
        ex_wr = 1'b0;
        if (ra[WORD_W-1]) begin
          ex_next  = pc + off;
          ex_taken = 1'b1;
        end
      end
      OP_JMP: begin
        ex_wr    = 1'b0;
        ex_next  = ra;
        ex_taken = 1'b1;
      end
      default: begin
        ex_wr    = 1'b0;
        ex_valid = 1'b0;
        ex_next  = pc;
      end
    endcase
  end

  always_comb begin
    res        = '0;
    pc_next    = pc;
    fin        = 1'b0;
    state_next = state;
    imem_we    = 1'b0;
    imem_re    = 1'b0;
    imem_wa    = addr_q[INSTR_ADDR_BITS-1:0];
    imem_wd    = wval_q;
    dmem_we    = 1'b0;
    dmem_re    = 1'b0;
    dmem_wa    = addr_q[DATA_ADDR_BITS-1:0];
    dmem_ra    = addr_q[DATA_ADDR_BITS-1:0];
    dmem_wd    = wval_q;
    rf_we      = 1'b0;
    rf_re      = 1'b0;
    rf_wa      = addr_q[REG_IDX_W-1:0];
    rf_wd      = wval_q;
    rf_ra_a    = fa;
    rf_ra_b    = fb;
    unique case (state)
      ST_CLEAR: begin
        imem_we = 1'b1;
        imem_wa = clr_cnt[INSTR_ADDR_BITS-1:0];
        imem_wd = '0;
        dmem_we = 1'b1;
        dmem_wa = clr_cnt[DATA_ADDR_BITS-1:0];
        dmem_wd = '0;
        if (&clr_cnt) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
      end
      ST_FETCH: begin
        unique case (req_q)
          REQ_STEP: begin
            imem_re    = 1'b1;
            state_next = ST_REGRD;
          end
          REQ_RD_DATA: begin
            dmem_re    = 1'b1;
            state_next = ST_RDOUT;
          end
          REQ_RD_REG: begin
            rf_re      = 1'b1;
            rf_ra_a    = addr_q[REG_IDX_W-1:0];
            state_next = ST_RDOUT;
          end
          REQ_WR_INSTR: begin
            fin     = out_free;
            imem_we = out_free;
          end
          REQ_WR_DATA: begin
            fin     = out_free;
            dmem_we = out_free;
          end
          REQ_WR_REG: begin
            fin   = out_free;
            rf_we = out_free;
          end
          REQ_SET_PC: begin
            fin = out_free;
            if (out_free) begin
              pc_next = wval_q;
            end
          end
          REQ_NONE: fin = out_free;
          default:  fin = out_free;
        endcase
      end
      ST_RDOUT: begin
        fin           = out_free;
        res.read_data = (req_q == REQ_RD_DATA) ? dmem_q : ra;
      end
      ST_REGRD: begin
        rf_re      = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        res.fetched_word = ir_q;
        if (ex_ld) begin
          dmem_re    = 1'b1;
          dmem_ra    = daddr;
          state_next = ST_MEMRD;
        end else begin
          fin                = out_free;
          res.invalid_opcode = !ex_valid;
          res.branch_taken   = ex_taken;
          res.reg_write_en   = ex_wr;
          res.reg_index      = ex_wr ? fd : '0;
          res.reg_value      = ex_wr ? ex_v : '0;
          res.mem_write_en   = ex_st;
          res.mem_address    = ex_st ? WORD_W'(daddr) : '0;
          res.mem_value      = ex_st ? rb : '0;
          rf_wa              = fd;
          rf_wd              = ex_v;
          rf_we              = out_free && ex_wr;
          dmem_wa            = daddr;
          dmem_wd            = rb;
          dmem_we            = out_free && ex_st;
          if (out_free) begin
            pc_next = ex_next;
          end
        end
      end
      ST_MEMRD: begin
        fin              = out_free;
        res.fetched_word = ir_q;
        res.reg_write_en = 1'b1;
        res.reg_index    = fd;
        res.reg_value    = dmem_q;
        res.mem_address  = WORD_W'(daddr);
        rf_wa            = fd;
        rf_wd            = dmem_q;
        rf_we            = out_free;
        if (out_free) begin
          pc_next = pc_inc;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (fin) begin
      state_next = ST_IDLE;
    end
    if (accept) begin
      state_next = ST_FETCH;
    end
    res.pc_after = pc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      pc        <= '0;
      rf_vld    <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + CLR_BITS'(1);
      end
      if (rf_we) begin
        rf_vld[rf_wa] <= 1'b1;
      end
      if (fin) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= req_t'(req_type);
      addr_q <= target_address;
      wval_q <= write_value;
    end
    if (fin) begin
      res_q <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (imem_we) begin
      imem[imem_wa] <= imem_wd;
    end
    if (imem_re) begin
      ir_q <= imem[pc[INSTR_ADDR_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (dmem_we) begin
      dmem[dmem_wa] <= dmem_wd;
    end
    if (dmem_re) begin
      dmem_q <= dmem[dmem_ra];
    end
  end

  // entries never written read as zero through the valid bits
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
    if (rf_re) begin
      ra_q     <= rf[rf_ra_a];
      ra_vld_q <= rf_vld[rf_ra_a];
      rb_q     <= rf[rf_ra_b];
      rb_vld_q <= rf_vld[rf_ra_b];
    end
  end

  assign pc_after       = res_q.pc_after;
  assign fetched_word   = res_q.fetched_word;
  assign invalid_opcode = res_q.invalid_opcode;
  assign branch_taken   = res_q.branch_taken;
  assign reg_write_en   = res_q.reg_write_en;
  assign reg_index      = res_q.reg_index;
  assign reg_value      = res_q.reg_value;
  assign mem_write_en   = res_q.mem_write_en;
  assign mem_address    = res_q.mem_address;
  assign mem_value      = res_q.mem_value;
  assign read_data      = res_q.read_data;

endmodule

`default_nettype wire

// ===== hdl/scis_checker.sv =====
// Port-level checker for simple_cpu_instruction_step, with its bind statement.
// Depends on scis_pkg for field widths.
`default_nettype none

module scis_checker
  import scis_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 res_valid,
  input logic                 res_stall,
  input logic [WORD_W-1:0]    pc_after,
  input logic                 invalid_opcode,
  input logic                 branch_taken,
  input logic                 reg_write_en,
  input logic [REG_IDX_W-1:0] reg_index,
  input logic [WORD_W-1:0]    reg_value,
  input logic                 mem_write_en
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result item dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(pc_after) && $stable(reg_value))
    else $error("stalled result item changed");

  a_invalid_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && invalid_opcode |-> !reg_write_en && !mem_write_en && !branch_taken)
    else $error("invalid opcode reported a side effect");

  a_store_only: assert property (@(posedge clk) disable iff (rst)
    res_valid && mem_write_en |-> !reg_write_en && !branch_taken)
    else $error("store combined with register write or branch");

  a_no_wr_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !reg_write_en |-> (reg_index == '0) && (reg_value == '0))
    else $error("register fields set without a register write");

endmodule

bind simple_cpu_instruction_step scis_checker u_scis_checker (.*);

`default_nettype wire

// ===== dv/tb_simple_cpu_instruction_step.sv =====
// Testbench for simple_cpu_instruction_step: directed and random requests against an in-bench
// predictor of the core, with random idling on both channels. Depends on scis_pkg and the RTL.
`timescale 1ns / 1ps

module tb_simple_cpu_instruction_step;
  import scis_pkg::*;

  localparam int          TIMEOUT_CYCLES = 400000;
  localparam int          ITEM_TARGET    = 540;
  localparam logic [15:0] DADDR_MASK     = 16'(DMEM_DEPTH - 1);
  localparam logic [6:0]  OP_UNDEF       = 7'h7F;

  class step_result_board;
    logic [WORD_W-1:0] regs [REG_NUM];
    logic [WORD_W-1:0] pc;
    logic [WORD_W-1:0] imem [IMEM_DEPTH];
    logic [WORD_W-1:0] dmem [DMEM_DEPTH];
    result_t           pending_results [$];
    int                errors;
    int                checked;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (imem[i]) imem[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc      = '0;
      errors  = 0;
      checked = 0;
    endfunction

    function void note_request(logic [2:0] req, logic [15:0] addr, logic [15:0] wval);
      result_t     r;
      logic [15:0] ir, ra, rb, v, nxt, off;
      logic [6:0]  op;
      logic [2:0]  d, a, b;
      logic        wr, ok;
      r = '0;
      case (req)
        REQ_STEP: begin
          ir  = imem[pc[INSTR_ADDR_BITS-1:0]];
          op  = ir[15:9];
          d   = ir[8:6];
          a   = ir[5:3];
          b   = ir[2:0];
          ra  = regs[a];
          rb  = regs[b];
          off = {{10{d[2]}}, d, b};
          nxt = pc + 16'd1;
          wr  = 1'b1;
          ok  = 1'b1;
          v   = '0;
          r.fetched_word = ir;
          case (op)
            OP_MOVA: v = ra;
            OP_INC:  v = ra + 16'd1;
            OP_ADD:  v = ra + rb;
            OP_SUB:  v = ra - rb;
            OP_DEC:  v = ra - 16'd1;
            OP_AND:  v = ra & rb;
            OP_OR:   v = ra | rb;
            OP_XOR:  v = ra ^ rb;
            OP_NOT:  v = ~ra;
            OP_MOVB: v = rb;
            OP_SHR:  v = rb >> 1;
            OP_SHL:  v = rb << 1;
            OP_LDI:  v = {13'd0, b};
            OP_ADI:  v = ra + {13'd0, b};
            OP_LD: begin
              v = dmem[ra[DATA_ADDR_BITS-1:0]];
              r.mem_address = ra & DADDR_MASK;
            end
            OP_ST: begin
              wr = 1'b0;
              dmem[ra[DATA_ADDR_BITS-1:0]] = rb;
              r.mem_write_en = 1'b1;
              r.mem_address  = ra & DADDR_MASK;
              r.mem_value    = rb;
            end
            OP_BRZ, OP_BRN: begin
              wr = 1'b0;
              if ((op == OP_BRZ) ? (ra == 16'd0) : ra[15]) begin
                nxt = pc + off;
                r.branch_taken = 1'b1;
              end
            end
            OP_JMP: begin
              wr  = 1'b0;
              nxt = ra;
              r.branch_taken = 1'b1;
            end
            default: begin
              wr = 1'b0;
              ok = 1'b0;
            end
          endcase
          if (ok) begin
            if (wr) begin
              regs[d] = v;
              r.reg_write_en = 1'b1;
              r.reg_index    = d;
              r.reg_value    = v;
            end
            pc = nxt;
          end else begin
            r.invalid_opcode = 1'b1;
          end
        end
        REQ_WR_INSTR: imem[addr[INSTR_ADDR_BITS-1:0]] = wval;
        REQ_WR_DATA:  dmem[addr[DATA_ADDR_BITS-1:0]] = wval;
        REQ_RD_DATA:  r.read_data = dmem[addr[DATA_ADDR_BITS-1:0]];
        REQ_WR_REG:   regs[addr[2:0]] = wval;
        REQ_SET_PC:   pc = wval;
        REQ_RD_REG:   r.read_data = regs[addr[2:0]];
        default: ;
      endcase
      r.pc_after = pc;
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %h, got %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        checked++;
        compare_field("pc_after", want.pc_after, got.pc_after);
        compare_field("fetched_word", want.fetched_word, got.fetched_word);
        compare_field("invalid_opcode", 16'(want.invalid_opcode), 16'(got.invalid_opcode));
        compare_field("branch_taken", 16'(want.branch_taken), 16'(got.branch_taken));
        compare_field("reg_write_en", 16'(want.reg_write_en), 16'(got.reg_write_en));
        compare_field("reg_index", 16'(want.reg_index), 16'(got.reg_index));
        compare_field("reg_value", want.reg_value, got.reg_value);
        compare_field("mem_write_en", 16'(want.mem_write_en), 16'(got.mem_write_en));
        compare_field("mem_address", want.mem_address, got.mem_address);
        compare_field("mem_value", want.mem_value, got.mem_value);
        compare_field("read_data", want.read_data, got.read_data);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  logic [2:0]           req_type;
  logic [WORD_W-1:0]    target_address;
  logic [WORD_W-1:0]    write_value;
  logic                 res_valid;
  logic                 res_stall;
  logic [WORD_W-1:0]    pc_after;
  logic [WORD_W-1:0]    fetched_word;
  logic                 invalid_opcode;
  logic                 branch_taken;
  logic                 reg_write_en;
  logic [REG_IDX_W-1:0] reg_index;
  logic [WORD_W-1:0]    reg_value;
  logic                 mem_write_en;
  logic [WORD_W-1:0]    mem_address;
  logic [WORD_W-1:0]    mem_value;
  logic [WORD_W-1:0]    read_data;

  step_result_board board;
  int               cycles;
  int               items_sent;

  simple_cpu_instruction_step uut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req_type       (req_type),
    .target_address (target_address),
    .write_value    (write_value),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .pc_after       (pc_after),
    .fetched_word   (fetched_word),
    .invalid_opcode (invalid_opcode),
    .branch_taken   (branch_taken),
    .reg_write_en   (reg_write_en),
    .reg_index      (reg_index),
    .reg_value      (reg_value),
    .mem_write_en   (mem_write_en),
    .mem_address    (mem_address),
    .mem_value      (mem_value),
    .read_data      (read_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit quiet_phase();
    return ((cycles / 1500) % 4) == 1;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase() || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] encode(logic [6:0] op, logic [2:0] d, logic [2:0] a,
                                         logic [2:0] b);
    return {op, d, a, b};
  endfunction

  function automatic logic [15:0] odd_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_instr();
    logic [6:0] op;
    if ($urandom_range(0, 9) == 0) begin
      op = 7'($urandom_range(0, 127));
    end else begin
      case ($urandom_range(0, 18))
        0:  op = OP_MOVA;
        1:  op = OP_INC;
        2:  op = OP_ADD;
        3:  op = OP_SUB;
        4:  op = OP_DEC;
        5:  op = OP_AND;
        6:  op = OP_OR;
        7:  op = OP_XOR;
        8:  op = OP_NOT;
        9:  op = OP_MOVB;
        10: op = OP_SHR;
        11: op = OP_SHL;
        12: op = OP_LDI;
        13: op = OP_ADI;
        14: op = OP_LD;
        15: op = OP_ST;
        16: op = OP_BRZ;
        17: op = OP_BRN;
        default: op = OP_JMP;
      endcase
    end
    return {op, 9'($urandom)};
  endfunction

  task automatic send(logic [2:0] req, logic [15:0] addr, logic [15:0] wval);
    int n;
    n = idle_len();
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    req_valid      <= 1'b1;
    req_type       <= req;
    target_address <= addr;
    write_value    <= wval;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    board.note_request(req, addr, wval);
    items_sent++;
  endtask

  task automatic hold_until_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  // a short program: operand set-up, load words, usually point pc at them, step through, maybe read back
  task automatic run_program();
    int          n, k;
    logic [15:0] base;
    n = $urandom_range(1, 8);
    k = $urandom_range(0, 3);
    repeat (k) send(REQ_WR_REG, 16'($urandom), odd_word());
    if ($urandom_range(0, 2) == 0) send(REQ_WR_DATA, 16'($urandom), odd_word());
    case ($urandom_range(0, 3))
      0:       base = 16'hFFFF - 16'($urandom_range(0, 7));
      1:       base = 16'($urandom_range(0, 7));
      default: base = 16'($urandom);
    endcase
    for (int i = 0; i < n; i++) send(REQ_WR_INSTR, base + 16'(i), random_instr());
    if ($urandom_range(0, 5) != 0) send(REQ_SET_PC, 16'($urandom), base);
    repeat (n) send(REQ_STEP, 16'($urandom), 16'($urandom));
    if ($urandom_range(0, 2) == 0) send(REQ_RD_REG, 16'($urandom), 16'($urandom));
    if ($urandom_range(0, 4) == 0) send(REQ_RD_DATA, 16'($urandom), 16'($urandom));
  endtask

  task automatic noise_item();
    logic [2:0] req;
    req = ($urandom_range(0, 39) == 0) ? REQ_NONE : 3'($urandom_range(0, 6));
    send(req, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    board          = new();
    cycles         = 0;
    items_sent     = 0;
    rst            = 1'b1;
    req_valid      = 1'b0;
    req_type       = REQ_STEP;
    target_address = '0;
    write_value    = '0;
    res_stall      = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send(REQ_RD_REG, 16'h0000, 16'h0000);
    send(REQ_RD_DATA, 16'hFFFF, 16'h0000);
    send(REQ_WR_REG, 16'hFFFF, 16'hFFFF);
    send(REQ_WR_REG, 16'h0008, 16'h8000);
    send(REQ_WR_DATA, 16'hFFFF, 16'hA5A5);
    send(REQ_RD_DATA, 16'h0FFF, 16'h0000);
    send(REQ_SET_PC, 16'h0000, 16'hFFFF);
    // negative branch, offset minus one
    send(REQ_WR_INSTR, 16'hFFFF, encode(OP_BRN, 3'd7, 3'd0, 3'd7));
    send(REQ_STEP, 16'h0000, 16'h0000);
    send(REQ_WR_INSTR, 16'hFFFE, encode(OP_ADD, 3'd1, 3'd7, 3'd0));
    send(REQ_STEP, 16'hFFFF, 16'hFFFF);
    // untaken branch, pc wraps to zero
    send(REQ_WR_INSTR, 16'hFFFF, encode(OP_BRZ, 3'd0, 3'd1, 3'd0));
    send(REQ_STEP, 16'h0000, 16'h0000);
    send(REQ_WR_INSTR, 16'h0000, encode(OP_UNDEF, 3'd7, 3'd7, 3'd7));
    send(REQ_STEP, 16'h0000, 16'h0000);
    send(REQ_WR_INSTR, 16'h0000, encode(OP_ST, 3'd0, 3'd7, 3'd0));
    send(REQ_STEP, 16'h0000, 16'h0000);
    send(REQ_WR_INSTR, 16'h0001, encode(OP_LD, 3'd2, 3'd7, 3'd0));
    send(REQ_STEP, 16'h0000, 16'h0000);
    send(REQ_WR_INSTR, 16'h0002, encode(OP_JMP, 3'd0, 3'd7, 3'd0));
    send(REQ_STEP, 16'h0000, 16'h0000);
    send(REQ_RD_REG, 16'h0002, 16'h0000);
    send(REQ_NONE, 16'hFFFF, 16'hFFFF);
    // taken zero branch, largest forward offset
    send(REQ_WR_INSTR, 16'hFFFF, encode(OP_BRZ, 3'd3, 3'd3, 3'd7));
    send(REQ_STEP, 16'h0000, 16'h0000);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent > 300 && items_sent < 320) hold_until_drained();
      if ($urandom_range(0, 4) == 0) noise_item();
      else run_program();
    end

    hold_until_drained();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // result side: random stall bursts, one long hold once traffic is flowing
  initial begin : result_side
    int  n;
    bit  long_hold_done;
    long_hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && board.checked >= 150) begin
        long_hold_done = 1'b1;
        res_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else if (quiet_phase()) begin
        res_stall <= 1'b0;
        @(posedge clk);
      end else begin
        res_stall <= ($urandom_range(0, 2) == 0);
        n = idle_len();
        repeat (n + 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      board.check_result({pc_after, fetched_word, invalid_opcode, branch_taken, reg_write_en,
                          reg_index, reg_value, mem_write_en, mem_address, mem_value,
                          read_data});
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

// ===== files.f =====
hdl/scis_pkg.sv
hdl/simple_cpu_instruction_step.sv
hdl/scis_checker.sv
dv/tb_simple_cpu_instruction_step.sv
